@@ rtl/core/fisr_pkg.sv @@
package fisr_pkg;

  localparam int unsigned StageCount = 10;

  localparam logic [31:0] GuessMagic = 32'h5f3759df;
  localparam logic [31:0] FpHalf     = 32'h3f000000;
  localparam logic [31:0] FpOneHalf  = 32'h3fc00000;
  localparam logic [31:0] QuietBit   = 32'h00400000;
  localparam logic [31:0] DefaultNan = 32'h7fc00000;
  localparam logic [7:0]  ExpMax     = 8'hff;

  function automatic logic is_nan(input logic [31:0] b);
    return (b[30:23] == ExpMax) && (b[22:0] != 23'd0);
  endfunction

  // Normalize a nonzero magnitude m, where eb is the biased exponent that
  // belongs to a leading one at bit 51, then round to nearest even and pack.
  function automatic logic [31:0] round_pack(input logic sgn,
                                             input logic signed [11:0] eb,
                                             input logic [51:0] m);
    logic [5:0]         lz;
    logic [51:0]        s;
    logic [51:0]        t;
    logic signed [11:0] be;
    logic [5:0]         sh;
    logic [23:0]        keep;
    logic               g;
    logic               st;
    logic               lost;
    logic [7:0]         ef;
    logic [30:0]        mag;
    lz = 6'd0;
    for (int i = 0; i < 52; i++) begin
      if (m[i]) lz = 6'(51 - i);
    end
    s  = m << lz;
    be = eb - $signed({6'b0, lz});
    if (be >= 12'sd255) begin
      return {sgn, ExpMax, 23'd0};
    end
    if (be >= 12'sd1) begin
      t    = s;
      ef   = be[7:0];
      lost = 1'b0;
    end else begin
      sh   = (be < -12'sd50) ? 6'd52 : 6'(12'sd1 - be);
      t    = s >> sh;
      lost = ((t << sh) != s);
      ef   = 8'd0;
    end
    keep = t[51:28];
    g    = t[27];
    st   = (|t[26:0]) | lost;
    // Carry out of the fraction moves into the exponent field on its own.
    mag  = {ef, keep[22:0]} + 31'(g & (st | keep[0]));
    return {sgn, mag};
  endfunction

endpackage

@@ rtl/core/fisr_fmul.sv @@
module fisr_fmul (
  input  logic        clk,
  input  logic        ce,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] res
);
  import fisr_pkg::*;

  logic [7:0]         ea, eb;
  logic [23:0]        ma, mb;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  logic               s1_sign;
  logic               s1_nan, s1_inf, s1_zero;
  logic signed [11:0] s1_exp;
  logic [47:0]        s1_prod;

  always_comb begin
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    a_nan  = is_nan(a);
    b_nan  = is_nan(b);
    a_inf  = (a[30:23] == ExpMax) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == ExpMax) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_sign <= a[31] ^ b[31];
      s1_nan  <= a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
      s1_inf  <= a_inf | b_inf;
      s1_zero <= a_zero | b_zero;
      s1_exp  <= $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd122;
      s1_prod <= ma * mb;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (s1_nan) begin
        res <= DefaultNan;
      end else if (s1_inf) begin
        res <= {s1_sign, ExpMax, 23'd0};
      end else if (s1_zero) begin
        res <= {s1_sign, 31'd0};
      end else begin
        res <= round_pack(s1_sign, s1_exp, {4'b0, s1_prod});
      end
    end
  end

endmodule

@@ rtl/core/fisr_fadd.sv @@
module fisr_fadd (
  input  logic        clk,
  input  logic        ce,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] res
);
  import fisr_pkg::*;

  logic [31:0] big, sml;
  logic [7:0]  e_big, e_sml, d;
  logic [5:0]  dd;
  logic [49:0] b_full, b_sh;
  logic        a_nan, b_nan, a_inf, b_inf;

  logic        s1_sign, s1_sub, s1_nan, s1_inf, s1_inf_sign, s1_zero, s1_zero_sign;
  logic [7:0]  s1_exp;
  logic [49:0] s1_a, s1_b;
  logic [50:0] sum;

  always_comb begin
    // Order the operands by magnitude so the difference stays nonnegative.
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    e_big  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d      = e_big - e_sml;
    dd     = (d > 8'd63) ? 6'd63 : d[5:0];
    b_full = {sml[30:23] != 8'd0, sml[22:0], 26'd0};
    b_sh   = b_full >> dd;
    b_sh[0] = b_sh[0] | ((b_sh << dd) != b_full);
    a_nan  = is_nan(a);
    b_nan  = is_nan(b);
    a_inf  = (a[30:23] == ExpMax) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == ExpMax) && (b[22:0] == 23'd0);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_sign      <= big[31];
      s1_sub       <= a[31] ^ b[31];
      s1_nan       <= a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
      s1_inf       <= a_inf | b_inf;
      s1_inf_sign  <= a_inf ? a[31] : b[31];
      s1_zero      <= (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
      s1_zero_sign <= a[31] & b[31];
      s1_exp       <= e_big;
      s1_a         <= {big[30:23] != 8'd0, big[22:0], 26'd0};
      s1_b         <= b_sh;
    end
  end

  assign sum = s1_sub ? ({1'b0, s1_a} - {1'b0, s1_b}) : ({1'b0, s1_a} + {1'b0, s1_b});

  always_ff @(posedge clk) begin
    if (ce) begin
      if (s1_nan) begin
        res <= DefaultNan;
      end else if (s1_inf) begin
        res <= {s1_inf_sign, ExpMax, 23'd0};
      end else if (s1_zero) begin
        res <= {s1_zero_sign, 31'd0};
      end else if (sum == 51'd0) begin
        res <= 32'd0;
      end else begin
        res <= round_pack(s1_sign, $signed({4'b0, s1_exp}) + 12'sd2, {1'b0, sum});
      end
    end
  end

endmodule

@@ rtl/core/fast_inverse_sqrt_core.sv @@
// Channel  | valid          | stall          | payload
// operand  | operand_valid  | operand_stall  | operand_bits [31:0]
// result   | result_valid   | result_stall   | result_bits  [31:0]
//
// Ten register stages: four two-stage multipliers and one two-stage adder in
// series. One transaction enters per cycle while the result is not stalled.
// rst clears the valid bits only.
// A stalled result holds the whole pipeline; operand_stall follows it.
module fast_inverse_sqrt_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        operand_valid,
  output logic        operand_stall,
  input  logic [31:0] operand_bits,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] result_bits
);
  import fisr_pkg::*;

  logic                  ce;
  logic [StageCount-1:0] vld;
  logic [31:0]           xp [StageCount];
  logic [31:0]           yp [StageCount];
  logic [31:0]           t_half, t_y1, t_y2, t_diff, r;

  assign ce            = !(vld[StageCount-1] && result_stall);
  assign operand_stall = !ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[StageCount-2:0], operand_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      xp[0] <= operand_bits;
      yp[0] <= GuessMagic - {1'b0, operand_bits[31:1]};
      for (int i = 1; i < StageCount; i++) begin
        xp[i] <= xp[i-1];
        yp[i] <= yp[i-1];
      end
    end
  end

  fisr_fmul u_mul_half (.clk, .ce, .a(operand_bits), .b(FpHalf), .res(t_half));
  fisr_fmul u_mul_y1   (.clk, .ce, .a(t_half), .b(yp[1]), .res(t_y1));
  fisr_fmul u_mul_y2   (.clk, .ce, .a(t_y1), .b(yp[3]), .res(t_y2));
  fisr_fadd u_sub      (.clk, .ce, .a(FpOneHalf), .b({~t_y2[31], t_y2[30:0]}),
                        .res(t_diff));
  fisr_fmul u_mul_out  (.clk, .ce, .a(yp[7]), .b(t_diff), .res(r));

  always_comb begin
    result_bits = r;
    if (is_nan(r)) begin
      if (is_nan(xp[StageCount-1])) begin
        result_bits = xp[StageCount-1] | QuietBit;
      end else if (is_nan(yp[StageCount-1])) begin
        result_bits = yp[StageCount-1] | QuietBit;
      end else begin
        result_bits = DefaultNan;
      end
    end
  end

  assign result_valid = vld[StageCount-1];

endmodule

@@ rtl/core/fisr_checker.sv @@
module fisr_checker (
  input logic        clk,
  input logic        rst,
  input logic        operand_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [31:0] result_bits
);

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_bits))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    operand_stall == (result_valid && result_stall))
    else $error("operand stall does not track result stall");

  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // the first transaction after reset needs the full pipeline depth
  assert property (@(posedge clk) rst ##1 !rst |-> !result_valid [*9])
    else $error("result appeared too early");

endmodule

bind fast_inverse_sqrt_core fisr_checker u_fisr_checker (
  .clk, .rst, .operand_stall, .result_valid, .result_stall, .result_bits
);
